// ===== sv/lea_pkg.sv =====
// Shared types and constants of the LEA-128 cipher core.
// No dependencies; compile first.
package lea_pkg;

    localparam int unsigned LEA_ROUNDS = 24;
    localparam int unsigned RND_W      = $clog2(LEA_ROUNDS);
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned KEY_REG_W  = 64;

    typedef logic [RND_W-1:0]     t_rnd;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [31:0]          t_word;
    typedef logic [127:0]         t_blk;

    localparam t_cfg_idx CFG_KEY_LOW  = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_KEY_HIGH = t_cfg_idx'(1);

    localparam t_rnd RND_LAST = t_rnd'(LEA_ROUNDS - 1);

    localparam t_word DELTA0 = 32'hc3efe9db;
    localparam t_word DELTA1 = 32'h88c4d604;
    localparam t_word DELTA2 = 32'he789f229;
    localparam t_word DELTA3 = 32'hc6f98763;

    typedef struct packed {
        logic blk_load;
        logic ks_load;
        logic ks_step;
        t_rnd rk_waddr;
        logic rk_re;
        t_rnd rk_raddr;
        logic rnd_step;
        logic dec;
        logic out_load;
        logic key_lo_we;
        logic key_hi_we;
    } t_dp_cmd;

    function automatic t_word rol32(input t_word x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic t_word ror32(input t_word x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== sv/lea_ifs.sv =====
// Channel interfaces of the LEA-128 core: block in, block out, key config.
// Depends on lea_pkg.
interface lea_blk_if;
    logic             valid;
    logic             ready;
    logic             action;
    lea_pkg::t_word   in_word0;
    lea_pkg::t_word   in_word1;
    lea_pkg::t_word   in_word2;
    lea_pkg::t_word   in_word3;
    modport source (output valid, action, in_word0, in_word1, in_word2, in_word3,
                    input ready);
    modport sink   (input valid, action, in_word0, in_word1, in_word2, in_word3,
                    output ready);
endinterface

interface lea_res_if;
    logic             valid;
    logic             ready;
    lea_pkg::t_word   out_word0;
    lea_pkg::t_word   out_word1;
    lea_pkg::t_word   out_word2;
    lea_pkg::t_word   out_word3;
    modport source (output valid, out_word0, out_word1, out_word2, out_word3,
                    input ready);
    modport sink   (input valid, out_word0, out_word1, out_word2, out_word3,
                    output ready);
endinterface

interface lea_cfg_if;
    logic                                 valid;
    logic                                 ready;
    lea_pkg::t_cfg_idx                    index;
    logic [lea_pkg::KEY_REG_W-1:0]        data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/lea128_block_cipher_core.sv =====
// Top level of the LEA-128 block cipher core.
// Depends on lea_pkg, lea_ifs, lea_ctrl and lea_dp.
//
//   channel  role  carries
//   i_blk    sink  action, in_word0..in_word3 (one block per beat)
//   o_res    src   out_word0..out_word3 (one block per beat)
//   i_cfg    sink  index, data (key_low = 0, key_high = 1; always ready)
//
// After an item is accepted it is loaded, its first round key is read from the
// key store, its rounds run through the shared round unit and the result
// register is filled; only then can the next beat be taken. After reset or a
// key write the next item first runs key expansion. Synchronous active-low
// reset clears the sequencer and the key and marks the key schedule stale. A
// stalled result beat holds in its register; a new block is taken meanwhile
// and waits in its final state.
module lea128_block_cipher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lea_blk_if.sink     i_blk,
    lea_res_if.source   o_res,
    lea_cfg_if.sink     i_cfg
);
    import lea_pkg::*;

    t_dp_cmd cmd;
    t_blk    res;

    assign i_cfg.ready = 1'b1;

    lea_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_blk_valid  (i_blk.valid),
        .i_blk_action (i_blk.action),
        .o_blk_ready  (i_blk.ready),
        .i_res_ready  (o_res.ready),
        .o_res_valid  (o_res.valid),
        .i_cfg_valid  (i_cfg.valid),
        .i_cfg_index  (i_cfg.index),
        .o_cmd        (cmd)
    );

    lea_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_cfg_data (i_cfg.data),
        .i_blk      ({i_blk.in_word3, i_blk.in_word2, i_blk.in_word1, i_blk.in_word0}),
        .o_res      (res)
    );

    assign o_res.out_word0 = res[31:0];
    assign o_res.out_word1 = res[63:32];
    assign o_res.out_word2 = res[95:64];
    assign o_res.out_word3 = res[127:96];

endmodule

// ===== sv/lea_ctrl.sv =====
// Sequencer of the LEA-128 core: key expansion, round stepping, result hand-off.
// Depends on lea_pkg.
module lea_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_blk_valid,
    input  logic              i_blk_action,
    output logic              o_blk_ready,
    input  logic              i_res_ready,
    output logic              o_res_valid,
    input  logic              i_cfg_valid,
    input  lea_pkg::t_cfg_idx i_cfg_index,
    output lea_pkg::t_dp_cmd  o_cmd
);
    import lea_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_KEXP  = 3'd1;
    localparam logic [2:0] S_PREF  = 3'd2;
    localparam logic [2:0] S_ROUND = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state, n_state;
    t_rnd       r_cnt, n_cnt;
    logic       r_dec, n_dec;
    logic       r_keys_ready, n_keys_ready;
    logic       r_res_valid, n_res_valid;

    function automatic t_rnd rk_addr(input logic dec, input t_rnd idx);
        return dec ? t_rnd'(RND_LAST - idx) : idx;
    endfunction

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_dec        = r_dec;
        n_keys_ready = r_keys_ready;
        n_res_valid  = r_res_valid && !i_res_ready;
        o_blk_ready  = 1'b0;
        o_cmd        = '0;
        o_cmd.dec    = r_dec;
        o_cmd.rk_waddr = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                o_blk_ready = 1'b1;
                if (i_blk_valid) begin
                    o_cmd.blk_load = 1'b1;
                    n_dec = i_blk_action;
                    n_cnt = '0;
                    if (!r_keys_ready) begin
                        o_cmd.ks_load = 1'b1;
                        n_state = S_KEXP;
                    end else begin
                        n_state = S_PREF;
                    end
                end
            end
            S_KEXP: begin
                o_cmd.ks_step = 1'b1;
                if (r_cnt == RND_LAST) begin
                    n_keys_ready = 1'b1;
                    n_cnt   = '0;
                    n_state = S_PREF;
                end else begin
                    n_cnt = r_cnt + t_rnd'(1);
                end
            end
            S_PREF: begin
                o_cmd.rk_re    = 1'b1;
                o_cmd.rk_raddr = rk_addr(r_dec, '0);
                n_cnt   = '0;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.rnd_step = 1'b1;
                if (r_cnt == RND_LAST) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rk_re    = 1'b1;
                    o_cmd.rk_raddr = rk_addr(r_dec, r_cnt + t_rnd'(1));
                    n_cnt = r_cnt + t_rnd'(1);
                end
            end
            S_DONE: begin
                if (!r_res_valid || i_res_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_res_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // the user must make key writes only while idle (unchecked by the block); drop the expanded schedule
        if (i_cfg_valid && i_cfg_index == CFG_KEY_LOW) begin
            o_cmd.key_lo_we = 1'b1;
            n_keys_ready = 1'b0;
        end
        if (i_cfg_valid && i_cfg_index == CFG_KEY_HIGH) begin
            o_cmd.key_hi_we = 1'b1;
            n_keys_ready = 1'b0;
        end
    end

    assign o_res_valid = r_res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_dec        <= 1'b0;
            r_keys_ready <= 1'b0;
            r_res_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_dec        <= n_dec;
            r_keys_ready <= n_keys_ready;
            r_res_valid  <= n_res_valid;
        end
    end

endmodule

// ===== sv/lea_dp.sv =====
// Datapath of the LEA-128 core: key registers, key schedule, round key store,
// shared round unit and result register. Depends on lea_pkg.
module lea_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lea_pkg::t_dp_cmd              i_cmd,
    input  logic [lea_pkg::KEY_REG_W-1:0] i_cfg_data,
    input  lea_pkg::t_blk                 i_blk,
    output lea_pkg::t_blk                 o_res
);
    import lea_pkg::*;

    logic [KEY_REG_W-1:0] r_key_lo, r_key_hi;
    t_word r_t0, r_t1, r_t2, r_t3;
    t_word r_d0, r_d1, r_d2, r_d3;
    t_word n_t0, n_t1, n_t2, n_t3;
    t_word r_x0, r_x1, r_x2, r_x3;
    t_word n_x0, n_x1, n_x2, n_x3;
    t_word k0, k1, k2, k3;
    t_blk  r_rk;
    t_blk  r_res;
    t_blk  rk_mem [LEA_ROUNDS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_lo <= '0;
            r_key_hi <= '0;
        end else begin
            if (i_cmd.key_lo_we) begin
                r_key_lo <= i_cfg_data;
            end
            if (i_cmd.key_hi_we) begin
                r_key_hi <= i_cfg_data;
            end
        end
    end

    // key schedule: one round key per cycle, delta queue rotates
    always_comb begin
        n_t0 = rol32(r_t0 + r_d0, 1);
        n_t1 = rol32(r_t1 + rol32(r_d0, 1), 3);
        n_t2 = rol32(r_t2 + rol32(r_d0, 2), 6);
        n_t3 = rol32(r_t3 + rol32(r_d0, 3), 11);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ks_load) begin
            r_t0 <= r_key_lo[31:0];
            r_t1 <= r_key_lo[63:32];
            r_t2 <= r_key_hi[31:0];
            r_t3 <= r_key_hi[63:32];
            r_d0 <= DELTA0;
            r_d1 <= DELTA1;
            r_d2 <= DELTA2;
            r_d3 <= DELTA3;
        end else if (i_cmd.ks_step) begin
            r_t0 <= n_t0;
            r_t1 <= n_t1;
            r_t2 <= n_t2;
            r_t3 <= n_t3;
            r_d0 <= r_d1;
            r_d1 <= r_d2;
            r_d2 <= r_d3;
            r_d3 <= rol32(r_d0, 4);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ks_step) begin
            rk_mem[i_cmd.rk_waddr] <= {n_t3, n_t2, n_t1, n_t0};
        end
        if (i_cmd.rk_re) begin
            r_rk <= rk_mem[i_cmd.rk_raddr];
        end
    end

    assign k0 = r_rk[31:0];
    assign k1 = r_rk[63:32];
    assign k2 = r_rk[95:64];
    assign k3 = r_rk[127:96];

    always_comb begin
        if (!i_cmd.dec) begin
            n_x0 = rol32((r_x0 ^ k0) + (r_x1 ^ k1), 9);
            n_x1 = ror32((r_x1 ^ k2) + (r_x2 ^ k1), 5);
            n_x2 = ror32((r_x2 ^ k3) + (r_x3 ^ k1), 3);
            n_x3 = r_x0;
        end else begin
            n_x0 = r_x3;
            n_x1 = (ror32(r_x0, 9) - (n_x0 ^ k0)) ^ k1;
            n_x2 = (rol32(r_x1, 5) - (n_x1 ^ k2)) ^ k1;
            n_x3 = (rol32(r_x2, 3) - (n_x2 ^ k3)) ^ k1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.blk_load) begin
            r_x0 <= i_blk[31:0];
            r_x1 <= i_blk[63:32];
            r_x2 <= i_blk[95:64];
            r_x3 <= i_blk[127:96];
        end else if (i_cmd.rnd_step) begin
            r_x0 <= n_x0;
            r_x1 <= n_x1;
            r_x2 <= n_x2;
            r_x3 <= n_x3;
        end
        if (i_cmd.out_load) begin
            r_res <= {r_x3, r_x2, r_x1, r_x0};
        end
    end

    assign o_res = r_res;

endmodule
